// ----- rtl/hex_frame_receiver_macros.svh -----
// Assertion macros for the hex frame receiver.
// Each use relies on clk and arst_n being visible in the enclosing module.
`ifndef HEX_FRAME_RECEIVER_MACROS_SVH
`define HEX_FRAME_RECEIVER_MACROS_SVH

`ifndef NO_ASSERTIONS

`define HFR_ASSERT_ALWAYS(lbl, expr, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (expr)) else $error(msg);

`define HFR_ASSERT_SAME(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

`define HFR_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`else

`define HFR_ASSERT_ALWAYS(lbl, expr, msg)

`define HFR_ASSERT_SAME(lbl, ante, cons, msg)

`define HFR_ASSERT_NEXT(lbl, ante, cons, msg)

`endif

`endif

// ----- rtl/hfr_pkg.sv -----
package hfr_pkg;

	localparam int BUFFER_BYTES_DEFAULT = 64;

	localparam int CFG_INDEX_W = 2;
	localparam logic [CFG_INDEX_W-1:0] CFG_OWN_ADDRESS = 2'd0;
	localparam logic [CFG_INDEX_W-1:0] CFG_END_MARKER  = 2'd1;

	localparam logic [7:0] OWN_ADDRESS_RESET = 8'd1;
	localparam logic [7:0] END_MARKER_RESET  = 8'd13;

	localparam logic [2:0] MODE_IDLE      = 3'd0;
	localparam logic [2:0] MODE_ADDRESSED = 3'd1;
	localparam logic [2:0] MODE_PAIR      = 3'd2;
	localparam logic [2:0] MODE_LOW       = 3'd3;
	localparam logic [2:0] MODE_ERROR     = 3'd4;
	localparam logic [2:0] MODE_OK        = 3'd5;

	localparam logic [7:0] CHAR_ZERO    = 8'h30;
	localparam logic [7:0] CHAR_NINE    = 8'h39;
	localparam logic [7:0] CHAR_UPPER_A = 8'h41;
	localparam logic [7:0] CHAR_UPPER_F = 8'h46;
	localparam logic [7:0] CHAR_LOWER_A = 8'h61;
	localparam logic [7:0] CHAR_LOWER_F = 8'h66;
	localparam logic [3:0] DIGIT_TEN    = 4'd10;

	typedef struct packed {
		logic [2:0] status;
		logic       store_valid;
		logic [5:0] store_index;
		logic [7:0] store_byte;
		logic [7:0] frame_command;
		logic [5:0] data_count;
	} result_t;

	typedef struct packed {
		logic [7:0] own_address;
		logic [7:0] end_marker;
	} cfg_t;

	// bit 4 set: not a hex digit
	function automatic logic [4:0] hex_digit(input logic [7:0] c);
		logic [7:0] d;
		d = 8'd0;
		if (c inside {[CHAR_ZERO:CHAR_NINE]}) begin
			d = c - CHAR_ZERO;
			return {1'b0, d[3:0]};
		end else if (c inside {[CHAR_UPPER_A:CHAR_UPPER_F]}) begin
			d = c - CHAR_UPPER_A;
			return {1'b0, d[3:0] + DIGIT_TEN};
		end else if (c inside {[CHAR_LOWER_A:CHAR_LOWER_F]}) begin
			d = c - CHAR_LOWER_A;
			return {1'b0, d[3:0] + DIGIT_TEN};
		end
		return 5'b10000;
	endfunction

endpackage

// ----- rtl/hfr_cfg.sv -----
module hfr_cfg (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_valid,
	output logic                           cfg_ready,
	input  logic [hfr_pkg::CFG_INDEX_W-1:0] cfg_index,
	input  logic [7:0]                     cfg_data,
	output hfr_pkg::cfg_t                  cfg
);
	import hfr_pkg::*;

	cfg_t cfg_q;

	assign cfg_ready = 1'b1;
	assign cfg = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.own_address <= OWN_ADDRESS_RESET;
			cfg_q.end_marker  <= END_MARKER_RESET;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				CFG_OWN_ADDRESS: cfg_q.own_address <= cfg_data;
				CFG_END_MARKER:  cfg_q.end_marker  <= cfg_data;
				default: ;
			endcase
		end
	end

endmodule

// ----- rtl/hfr_core.sv -----
module hfr_core #(
	parameter int BUFFER_BYTES = hfr_pkg::BUFFER_BYTES_DEFAULT
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             accept,
	input  logic             action,
	input  logic [7:0]       rx_byte,
	input  hfr_pkg::cfg_t    cfg,
	output hfr_pkg::result_t res
);
	import hfr_pkg::*;

	localparam int PCW = $clog2(BUFFER_BYTES);
	localparam logic [PCW:0] LIMIT = (PCW+1)'(BUFFER_BYTES);

	logic [2:0]     mode_q, mode_n;
	logic [7:0]     command_q, command_n;
	logic [PCW-1:0] pair_q, pair_n;
	logic [7:0]     check_q, check_n;
	logic [7:0]     pend_val_q, pend_val_n;
	logic [7:0]     pend_sum_q, pend_sum_n;
	logic [4:0]     digit;
	logic [7:0]     final_sum;
	logic [PCW:0]   pair_inc;
	logic [PCW-1:0] pair_dec;
	logic [PCW-1:0] pair_n_dec;

	assign digit      = hex_digit(rx_byte);
	assign final_sum  = check_q + pend_val_q;
	assign pair_inc   = {1'b0, pair_q} + 1'b1;
	assign pair_dec   = pair_q - 1'b1;
	assign pair_n_dec = pair_n - 1'b1;

	always_comb begin
		mode_n          = mode_q;
		command_n       = command_q;
		pair_n          = pair_q;
		check_n         = check_q;
		pend_val_n      = pend_val_q;
		pend_sum_n      = pend_sum_q;
		res.store_valid = 1'b0;
		res.store_index = 6'd0;
		res.store_byte  = 8'd0;
		if (action) begin
			mode_n = MODE_IDLE;
			pair_n = '0;
		end else begin
			case (mode_q)
				MODE_IDLE: begin
					if (rx_byte == cfg.own_address) mode_n = MODE_ADDRESSED;
				end
				MODE_ADDRESSED: begin
					command_n = rx_byte;
					check_n   = rx_byte;
					mode_n    = MODE_PAIR;
				end
				MODE_PAIR: begin
					if (rx_byte == cfg.end_marker) begin
						if (pair_q == '0) begin
							mode_n = MODE_ERROR;
						end else begin
							check_n = final_sum;
							mode_n  = (final_sum == 8'd0) ? MODE_OK : MODE_ERROR;
						end
					end else if (digit[4]) begin
						mode_n = MODE_ERROR;
					end else if (pair_inc >= LIMIT) begin
						mode_n = MODE_ERROR;
					end else begin
						if (pair_q != '0) begin
							res.store_valid = 1'b1;
							res.store_index = 6'(pair_dec);
							res.store_byte  = pend_val_q;
							check_n         = check_q + pend_sum_q;
						end
						pend_val_n = {digit[3:0], 4'b0000};
						pend_sum_n = rx_byte;
						mode_n     = MODE_LOW;
					end
				end
				MODE_LOW: begin
					if (rx_byte == cfg.end_marker || digit[4]) begin
						mode_n = MODE_ERROR;
					end else begin
						pend_val_n = pend_val_q | {4'b0000, digit[3:0]};
						pend_sum_n = pend_sum_q + rx_byte;
						pair_n     = pair_inc[PCW-1:0];
						mode_n     = MODE_PAIR;
					end
				end
				default: ;
			endcase
		end
		res.status        = mode_n;
		res.frame_command = command_n;
		res.data_count    = (mode_n == MODE_OK && pair_n != '0) ? 6'(pair_n_dec) : 6'd0;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q     <= MODE_IDLE;
			command_q  <= 8'd0;
			pair_q     <= '0;
			check_q    <= 8'd0;
			pend_val_q <= 8'd0;
			pend_sum_q <= 8'd0;
		end else if (accept) begin
			mode_q     <= mode_n;
			command_q  <= command_n;
			pair_q     <= pair_n;
			check_q    <= check_n;
			pend_val_q <= pend_val_n;
			pend_sum_q <= pend_sum_n;
		end
	end

`include "hex_frame_receiver_macros.svh"

	`HFR_ASSERT_NEXT(a_store_opens_low, accept && res.store_valid, mode_q == MODE_LOW, "store without low digit")
	`HFR_ASSERT_NEXT(a_rearm_clears, accept && action, mode_q == MODE_IDLE && pair_q == '0, "rearm failed")
	`HFR_ASSERT_NEXT(a_final_hold, accept && !action && (mode_q == MODE_ERROR || mode_q == MODE_OK), $stable(mode_q) && $stable(pair_q), "final mode left without rearm")
	`HFR_ASSERT_ALWAYS(a_pair_bound, {1'b0, pair_q} < LIMIT, "pair count beyond buffer")

endmodule

// ----- rtl/hfr_skid.sv -----
module hfr_skid (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  hfr_pkg::result_t push_data,
	output logic             full,
	output logic             result_valid,
	input  logic             result_stall,
	output hfr_pkg::result_t result_data
);
	import hfr_pkg::*;

	logic    out_valid_q;
	logic    skid_valid_q;
	result_t out_q;
	result_t skid_q;
	logic    pop;

	assign pop          = out_valid_q && !result_stall;
	assign full         = skid_valid_q;
	assign result_valid = out_valid_q;
	assign result_data  = out_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q  <= 1'b0;
			skid_valid_q <= 1'b0;
		end else if (skid_valid_q) begin
			if (pop) skid_valid_q <= 1'b0;
		end else if (push) begin
			if (out_valid_q && !pop) skid_valid_q <= 1'b1;
			out_valid_q <= 1'b1;
		end else if (pop) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (skid_valid_q) begin
			if (pop) out_q <= skid_q;
		end else if (push) begin
			if (out_valid_q && !pop) skid_q <= push_data;
			else out_q <= push_data;
		end
	end

`include "hex_frame_receiver_macros.svh"

	`HFR_ASSERT_ALWAYS(a_skid_behind_out, !skid_valid_q || out_valid_q, "skid beat without head beat")
	`HFR_ASSERT_NEXT(a_skid_fills, push && out_valid_q && result_stall, skid_valid_q && $stable(out_q), "stalled head lost on push")

endmodule

// ----- rtl/hex_frame_receiver.sv -----
// Hex frame receiver: takes one bus beat per cycle unless item_stall is high (action 0 = byte
// in rx_byte, action 1 = rearm to idle) and returns exactly one result beat for each. A frame
// is own_address, a command byte, ASCII hex pairs (either case) and end_marker; the last pair
// is the checksum, and each earlier pair leaves as a store write once the next pair starts.
// Status reaches 5 when command + data digit codes + checksum byte is 0 mod 256, and 4 on any
// fault, where it stays until rearm. Each beat is decoded in the same cycle it is taken, so one
// beat per cycle is sustained while results are not stalled; the result is registered, and a
// two-entry output buffer keeps input accepted while one result waits under stall. Write the
// registers only while no beat is in flight.
module hex_frame_receiver #(
	parameter int BUFFER_BYTES = hfr_pkg::BUFFER_BYTES_DEFAULT
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_valid,
	output logic                            cfg_ready,
	input  logic [hfr_pkg::CFG_INDEX_W-1:0] cfg_index,
	input  logic [7:0]                      cfg_data,
	input  logic                            item_valid,
	output logic                            item_stall,
	input  logic                            action,
	input  logic [7:0]                      rx_byte,
	output logic                            result_valid,
	input  logic                            result_stall,
	output logic [2:0]                      status,
	output logic                            store_valid,
	output logic [5:0]                      store_index,
	output logic [7:0]                      store_byte,
	output logic [7:0]                      frame_command,
	output logic [5:0]                      data_count
);
	import hfr_pkg::*;

	cfg_t    cfg;
	result_t core_res;
	result_t out_res;
	logic    accept;
	logic    full;

	assign item_stall = full;
	assign accept     = item_valid && !full;

	hfr_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	hfr_core #(
		.BUFFER_BYTES (BUFFER_BYTES)
	) u_core (
		.clk     (clk),
		.arst_n  (arst_n),
		.accept  (accept),
		.action  (action),
		.rx_byte (rx_byte),
		.cfg     (cfg),
		.res     (core_res)
	);

	hfr_skid u_skid (
		.clk          (clk),
		.arst_n       (arst_n),
		.push         (accept),
		.push_data    (core_res),
		.full         (full),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.result_data  (out_res)
	);

	assign status        = out_res.status;
	assign store_valid   = out_res.store_valid;
	assign store_index   = out_res.store_index;
	assign store_byte    = out_res.store_byte;
	assign frame_command = out_res.frame_command;
	assign data_count    = out_res.data_count;

endmodule

// ----- dv/tb.sv -----
module tb;
	timeunit 1ns;
	timeprecision 1ps;

	import hfr_pkg::*;

	localparam logic ACT_BYTE  = 1'b0;
	localparam logic ACT_REARM = 1'b1;

	localparam int MAX_DATA        = BUFFER_BYTES_DEFAULT - 2;
	localparam int NUM_PHASES      = 6;
	localparam int BEATS_PER_PHASE = 260;
	localparam int HOLD_OFF_CYCLES = 40;
	localparam int SETTLE_CYCLES   = 8;
	localparam int WATCHDOG_LIMIT  = 5000;

	typedef logic [7:0] byte_q_t[$];

	typedef enum int {
		FLAW_NONE,
		FLAW_BAD_SUM,
		FLAW_NON_HEX,
		FLAW_ODD_PAIR,
		FLAW_EMPTY
	} frame_flaw_e;

	typedef enum int {
		CASE_UPPER,
		CASE_LOWER,
		CASE_MIXED
	} letter_case_e;

	typedef struct {
		logic [7:0] own;
		logic [7:0] term;
		int         idle;
		int         stall;
		bit         pressure;
	} phase_plan_t;

	class frame_scoreboard;
		logic [7:0] own_address = OWN_ADDRESS_RESET;
		logic [7:0] end_marker  = END_MARKER_RESET;
		logic [2:0] mode = MODE_IDLE;
		logic [7:0] command_byte = 8'd0;
		logic [5:0] pairs_done = 6'd0;
		logic [7:0] running_sum = 8'd0;
		logic [7:0] held_byte = 8'd0;
		logic [7:0] held_char_sum = 8'd0;
		result_t    results_due[$];
		int         shown_limit = 10;
		int         mismatches = 0;
		int         checked = 0;
		int         frames_ok = 0;
		int         frames_bad = 0;
		int         stores = 0;

		function logic [4:0] digit_of(input logic [7:0] c);
			if (c >= CHAR_ZERO && c <= CHAR_NINE)
				return {1'b0, c[3:0]};
			if ((c >= CHAR_UPPER_A && c <= CHAR_UPPER_F) ||
					(c >= CHAR_LOWER_A && c <= CHAR_LOWER_F))
				return {1'b0, c[3:0] + 4'd9};
			return 5'b10000;
		endfunction

		function void write_register(input logic [CFG_INDEX_W-1:0] idx, input logic [7:0] val);
			if (idx == CFG_OWN_ADDRESS)
				own_address = val;
			else if (idx == CFG_END_MARKER)
				end_marker = val;
		endfunction

		function void decode_beat(input logic act, input logic [7:0] b);
			result_t    r;
			logic [4:0] nib;
			logic [2:0] prior;
			r = '0;
			prior = mode;
			nib = digit_of(b);
			if (act == ACT_REARM) begin
				mode = MODE_IDLE;
				pairs_done = 6'd0;
			end else begin
				case (mode)
				MODE_IDLE: begin
					if (b == own_address)
						mode = MODE_ADDRESSED;
				end
				MODE_ADDRESSED: begin
					command_byte = b;
					running_sum = b;
					mode = MODE_PAIR;
				end
				MODE_PAIR: begin
					if (b == end_marker) begin
						if (pairs_done == 6'd0) begin
							mode = MODE_ERROR;
						end else begin
							running_sum = running_sum + held_byte;
							mode = (running_sum == 8'd0) ? MODE_OK : MODE_ERROR;
						end
					end else if (nib[4]) begin
						mode = MODE_ERROR;
					end else if (int'(pairs_done) + 1 >= BUFFER_BYTES_DEFAULT) begin
						mode = MODE_ERROR;
					end else begin
						if (pairs_done != 6'd0) begin
							r.store_valid = 1'b1;
							r.store_index = pairs_done - 6'd1;
							r.store_byte = held_byte;
							running_sum = running_sum + held_char_sum;
							stores++;
						end
						held_byte = {nib[3:0], 4'h0};
						held_char_sum = b;
						mode = MODE_LOW;
					end
				end
				MODE_LOW: begin
					if (b == end_marker || nib[4]) begin
						mode = MODE_ERROR;
					end else begin
						held_byte = held_byte | {4'h0, nib[3:0]};
						held_char_sum = held_char_sum + b;
						pairs_done = pairs_done + 6'd1;
						mode = MODE_PAIR;
					end
				end
				default: begin
				end
				endcase
			end
			if (mode != prior && mode == MODE_OK)
				frames_ok++;
			if (mode != prior && mode == MODE_ERROR)
				frames_bad++;
			r.status = mode;
			r.frame_command = command_byte;
			r.data_count = (mode == MODE_OK && pairs_done != 6'd0) ? pairs_done - 6'd1 : 6'd0;
			results_due.push_back(r);
		endfunction

		function string show(input result_t r);
			return $sformatf("status=%0d store=%0b idx=%0d byte=%02h cmd=%02h count=%0d",
				r.status, r.store_valid, r.store_index, r.store_byte, r.frame_command,
				r.data_count);
		endfunction

		function void report(input string what);
			mismatches++;
			if (mismatches <= shown_limit)
				$display("%t MISMATCH result %0d: %s", $realtime, checked, what);
		endfunction

		function void check_result(input result_t got);
			result_t want;
			string   bad;
			checked++;
			if (results_due.size() == 0) begin
				report({"no result pending, actual ", show(got)});
				return;
			end
			want = results_due.pop_front();
			bad = "";
			if (got.status !== want.status)
				bad = {bad, " status"};
			if (got.store_valid !== want.store_valid)
				bad = {bad, " store_valid"};
			if (got.store_index !== want.store_index)
				bad = {bad, " store_index"};
			if (got.store_byte !== want.store_byte)
				bad = {bad, " store_byte"};
			if (got.frame_command !== want.frame_command)
				bad = {bad, " frame_command"};
			if (got.data_count !== want.data_count)
				bad = {bad, " data_count"};
			if (bad != "")
				report({"field", bad, ": expected ", show(want), " actual ", show(got)});
		endfunction

		function int outstanding();
			return results_due.size();
		endfunction
	endclass

	bit clk;
	logic arst_n;
	logic cfg_valid;
	logic cfg_ready;
	logic [CFG_INDEX_W-1:0] cfg_index;
	logic [7:0] cfg_data;
	logic item_valid;
	logic item_stall;
	logic action;
	logic [7:0] rx_byte;
	logic result_valid;
	logic result_stall;
	logic [2:0] status;
	logic store_valid;
	logic [5:0] store_index;
	logic [7:0] store_byte;
	logic [7:0] frame_command;
	logic [5:0] data_count;

	frame_scoreboard sb;
	result_t seen;
	int send_idle_pct;
	int stall_pct;
	int beats_sent;
	int settings_used;
	int hold_off_requests;
	int hold_off_served;
	int hold_off_left;
	int quiet_cycles;

	hex_frame_receiver u_top (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.item_valid   (item_valid),
		.item_stall   (item_stall),
		.action       (action),
		.rx_byte      (rx_byte),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.status       (status),
		.store_valid  (store_valid),
		.store_index  (store_index),
		.store_byte   (store_byte),
		.frame_command(frame_command),
		.data_count   (data_count)
	);

	always begin
		clk = 1'b0;
		#10;
		clk = 1'b1;
		#10;
	end

	// hold the result side off for a long stretch on request, else stall at random
	always @(negedge clk) begin
		if (hold_off_served != hold_off_requests) begin
			hold_off_served = hold_off_requests;
			hold_off_left = HOLD_OFF_CYCLES;
		end
		if (hold_off_left > 0) begin
			hold_off_left--;
			result_stall <= 1'b1;
		end else begin
			result_stall <= ($urandom_range(99) < stall_pct);
		end
	end

	always @(posedge clk) begin
		if (arst_n && result_valid && !result_stall) begin
			seen.status = status;
			seen.store_valid = store_valid;
			seen.store_index = store_index;
			seen.store_byte = store_byte;
			seen.frame_command = frame_command;
			seen.data_count = data_count;
			sb.check_result(seen);
		end
	end

	always @(posedge clk) begin
		if (!arst_n || (item_valid && !item_stall) || (result_valid && !result_stall) ||
				(cfg_valid && cfg_ready))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
	end

	initial begin
		wait (quiet_cycles >= WATCHDOG_LIMIT);
		$display("%t watchdog: no beat moved for %0d cycles, %0d results outstanding",
			$realtime, quiet_cycles, sb.outstanding());
		$display("*** FAILED ***");
		$finish;
	end

	function automatic logic [7:0] hex_char(input logic [3:0] nib, input letter_case_e lc);
		bit lower;
		lower = (lc == CASE_MIXED) ? bit'($urandom_range(1)) : (lc == CASE_LOWER);
		if (nib < DIGIT_TEN)
			return CHAR_ZERO + 8'(nib);
		return (lower ? CHAR_LOWER_A : CHAR_UPPER_A) + 8'(nib - DIGIT_TEN);
	endfunction

	function automatic logic [7:0] non_hex_byte();
		logic [7:0] c;
		logic [4:0] d;
		do begin
			c = 8'($urandom_range(255));
			d = sb.digit_of(c);
		end while (!d[4]);
		return c;
	endfunction

	function automatic byte_q_t build_frame(input logic [7:0] addr, input logic [7:0] cmd,
			input logic [7:0] term, input byte_q_t payload, input frame_flaw_e flaw,
			input letter_case_e lc);
		byte_q_t    seq;
		logic [7:0] sum;
		logic [7:0] chk;
		logic [7:0] hi;
		logic [7:0] lo;
		int         pos;
		seq.push_back(addr);
		seq.push_back(cmd);
		if (flaw == FLAW_EMPTY) begin
			seq.push_back(term);
			return seq;
		end
		sum = cmd;
		foreach (payload[i]) begin
			hi = hex_char(payload[i][7:4], lc);
			lo = hex_char(payload[i][3:0], lc);
			seq.push_back(hi);
			seq.push_back(lo);
			sum = sum + hi + lo;
		end
		chk = 8'h00 - sum;
		if (flaw == FLAW_BAD_SUM)
			chk = chk ^ 8'($urandom_range(255, 1));
		seq.push_back(hex_char(chk[7:4], lc));
		seq.push_back(hex_char(chk[3:0], lc));
		if (flaw == FLAW_ODD_PAIR)
			void'(seq.pop_back());
		if (flaw == FLAW_NON_HEX) begin
			pos = $urandom_range(seq.size() - 1, 2);
			seq[pos] = non_hex_byte();
		end
		seq.push_back(term);
		return seq;
	endfunction

	task automatic send_beat(input logic act, input logic [7:0] value);
		while ($urandom_range(99) < send_idle_pct) begin
			item_valid <= 1'b0;
			action <= 1'($urandom_range(1));
			rx_byte <= 8'($urandom_range(255));
			@(negedge clk);
		end
		item_valid <= 1'b1;
		action <= act;
		rx_byte <= value;
		@(posedge clk);
		while (item_stall)
			@(posedge clk);
		sb.decode_beat(act, value);
		beats_sent++;
		@(negedge clk);
	endtask

	task automatic send_seq(input byte_q_t seq);
		foreach (seq[i])
			send_beat(ACT_BYTE, seq[i]);
	endtask

	task automatic write_register(input logic [CFG_INDEX_W-1:0] idx, input logic [7:0] val);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		sb.write_register(idx, val);
		@(negedge clk);
	endtask

	task automatic settle_block();
		item_valid <= 1'b0;
		while (sb.outstanding() != 0)
			@(negedge clk);
		repeat (SETTLE_CYCLES)
			@(negedge clk);
	endtask

	task automatic send_random_frame();
		byte_q_t     payload;
		byte_q_t     seq;
		frame_flaw_e flaw;
		int          roll;
		int          n_data;
		roll = $urandom_range(99);
		if (roll >= 94) begin
			repeat ($urandom_range(8, 1))
				send_beat(($urandom_range(3) == 0) ? ACT_REARM : ACT_BYTE,
					8'($urandom_range(255)));
			return;
		end
		flaw = FLAW_NONE;
		if (roll >= 88)
			flaw = FLAW_BAD_SUM;
		else if (roll >= 83)
			flaw = FLAW_NON_HEX;
		else if (roll >= 79)
			flaw = FLAW_ODD_PAIR;
		else if (roll >= 76)
			flaw = FLAW_EMPTY;
		n_data = ($urandom_range(24) == 0) ? MAX_DATA : $urandom_range(6);
		// one pair too many for the buffer
		if (roll >= 73 && roll < 76)
			n_data = MAX_DATA + 1;
		repeat (n_data)
			payload.push_back(8'($urandom_range(255)));
		seq = build_frame(sb.own_address, 8'($urandom_range(255)), sb.end_marker, payload,
			flaw, CASE_MIXED);
		// cut the frame short; the next rearm aborts it
		if ($urandom_range(11) == 0)
			seq = seq[0:$urandom_range(seq.size() - 1)];
		send_beat(ACT_REARM, 8'($urandom_range(255)));
		repeat ($urandom_range(2))
			send_beat(ACT_BYTE, 8'($urandom_range(255)));
		send_seq(seq);
	endtask

	initial begin
		phase_plan_t plan[NUM_PHASES];
		byte_q_t     payload;
		int          phase_start;
		int          frames_in_phase;

		arst_n = 1'b0;
		cfg_valid = 1'b0;
		cfg_index = CFG_OWN_ADDRESS;
		cfg_data = 8'd0;
		item_valid = 1'b0;
		action = ACT_BYTE;
		rx_byte = 8'd0;
		result_stall = 1'b0;
		send_idle_pct = 0;
		stall_pct = 0;
		beats_sent = 0;
		settings_used = 1;
		hold_off_requests = 0;
		hold_off_served = 0;
		hold_off_left = 0;
		quiet_cycles = 0;
		sb = new;

		plan[0] = '{OWN_ADDRESS_RESET, END_MARKER_RESET, 0, 0, 1'b0};
		plan[1] = '{8'h00, 8'hFF, 52, 0, 1'b0};
		plan[2] = '{8'hFF, 8'h00, 0, 52, 1'b0};
		plan[3] = '{8'($urandom_range(255)), 8'($urandom_range(255)), 37, 37, 1'b0};
		plan[4] = '{8'h3A, CHAR_LOWER_A, 0, 0, 1'b1};
		plan[5] = '{OWN_ADDRESS_RESET, END_MARKER_RESET, 37, 37, 1'b0};

		repeat (6)
			@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		send_beat(ACT_REARM, 8'hFF);
		send_beat(ACT_BYTE, 8'h00);
		payload = '{8'h0F, 8'h9A};
		send_seq(build_frame(sb.own_address, 8'hFF, sb.end_marker, payload, FLAW_NONE,
			CASE_LOWER));
		send_beat(ACT_REARM, 8'h00);
		send_seq(build_frame(sb.own_address, 8'h00, sb.end_marker, payload, FLAW_EMPTY,
			CASE_UPPER));
		send_beat(ACT_BYTE, 8'hFF);
		send_beat(ACT_REARM, 8'h00);
		send_beat(ACT_BYTE, sb.own_address);
		send_beat(ACT_BYTE, 8'h5A);
		send_beat(ACT_BYTE, CHAR_UPPER_F);
		send_beat(ACT_BYTE, sb.end_marker);
		send_beat(ACT_REARM, 8'h00);
		send_beat(ACT_BYTE, sb.own_address);
		send_beat(ACT_BYTE, 8'hA5);
		send_beat(ACT_BYTE, CHAR_UPPER_F + 8'd1);

		for (int p = 0; p < NUM_PHASES; p++) begin
			if (p != 0) begin
				settle_block();
				write_register(CFG_OWN_ADDRESS, plan[p].own);
				write_register(CFG_END_MARKER, plan[p].term);
				cfg_valid <= 1'b0;
				settings_used++;
			end
			send_idle_pct = plan[p].idle;
			stall_pct <= plan[p].stall;
			phase_start = beats_sent;
			frames_in_phase = 0;
			while (beats_sent - phase_start < BEATS_PER_PHASE) begin
				if (plan[p].pressure && frames_in_phase % 8 == 0)
					hold_off_requests <= hold_off_requests + 1;
				send_random_frame();
				frames_in_phase++;
			end
		end

		settle_block();
		$display("Sent %0d beats under %0d address/terminator settings; %0d frames accepted,",
			beats_sent, settings_used, sb.frames_ok);
		$display("%0d rejected, %0d data bytes stored, %0d results checked, %0d mismatches.",
			sb.frames_bad, sb.stores, sb.checked, sb.mismatches);
		if (sb.mismatches == 0 && sb.outstanding() == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end

endmodule
